### hdl/topk_pkg.sv
// shared types and constants for the sorted newest-first insertion buffer
package topk_pkg;

  localparam int Capacity  = 32;
  localparam int TagBits   = 16;
  localparam int StampBits = 64;
  localparam int PosBits   = 6;
  localparam int CntBits   = 7;
  localparam int CfgBits   = 6;
  localparam int IdxBits   = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int HeldBits  = $clog2(Capacity + 1);
  localparam int AddrBits  = 3;

  localparam logic [CfgBits-1:0] MaxEntriesRst = 6'd32;
  localparam logic               KindInsert    = 1'b0;
  localparam logic               KindDump      = 1'b1;
  localparam logic               RegMaxEntries = 1'b0;

  typedef struct packed {
    logic                 kind;
    logic [StampBits-1:0] stamp;
    logic [TagBits-1:0]   tag;
  } item_t;

  typedef struct packed {
    logic                 accepted;
    logic [PosBits-1:0]   position;
    logic                 evicted;
    logic                 full_res;
    logic [CntBits-1:0]   count;
    logic                 entry_valid;
    logic [StampBits-1:0] entry_stamp;
    logic [TagBits-1:0]   entry_tag;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [StampBits-1:0] stamp;
    logic [TagBits-1:0]   tag;
  } entry_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_e;

endpackage

### hdl/bounded_topk_newest_insert.sv
// top level: sorted newest-first timestamp buffer built from a chain of cells
// Usage:
//   An item (insert or dump) is taken on a clock edge with start high and busy low.
//   Insert: the incoming stamp is compared against every cell at once; the chain
//   shifts by one past the insertion point in the same cycle. One result beat
//   appears with result_valid_o the cycle after the item is taken, so inserts can
//   be issued every cycle while busy is low.
//   Dump: the first n held entries rotate toward cell 0, one per cycle, and cell 0
//   is emitted each cycle while busy is high; each beat is registered and the
//   last one carries last.
//   An empty dump gives a single beat the cycle after the item.
//   Each result beat is shown for exactly one cycle; the receiver cannot stall.
//   The user writes max_entries via the APB-style port (byte address 0) while idle;
//   the block does not enforce it. 0 acts as 1, values above capacity as capacity.
//   Reset empties the list (stored entries are not cleared) and sets max_entries
//   to 32. Entry storage sits in flip-flops inside the cells, no clearing pass.
module bounded_topk_newest_insert import topk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  item_t               item_i,
  output logic                result_valid_o,
  output result_t             result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrBits-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  state_e                state_q, state_d;
  logic [HeldBits-1:0]   held_q, held_d;
  logic [IdxBits-1:0]    idx_q, idx_d;
  logic [CfgBits-1:0]    max_q;
  result_t               res_q, res_d;
  logic                  res_vld_q, res_vld_d;

  entry_t                ent   [Capacity];
  entry_t                left  [Capacity];
  entry_t                nxt   [Capacity];
  cell_op_e              op    [Capacity];
  logic [Capacity-1:0]   older, nnewer;
  logic [Capacity-1:0]   below, below_prev, older_prev, is_tail, is_end, hit, shift;
  entry_t                new_ent;

  logic [HeldBits-1:0]   lim;
  logic [CntBits-1:0]    max_w, lim_w, n1_w;
  logic                  take, insert_go, dump_go, dumping;
  logic                  append;
  logic [IdxBits-1:0]    pos_p;
  logic [HeldBits-1:0]   nc;
  logic                  ev;
  logic                  cfg_wr;
  logic                  dump_last;

  assign take      = start && !busy;
  assign insert_go = take && (item_i.kind == KindInsert);
  assign dump_go   = take && (item_i.kind == KindDump);
  assign dumping   = (state_q == ST_DUMP);
  assign busy      = dumping;

  assign new_ent.stamp = item_i.stamp;
  assign new_ent.tag   = item_i.tag;

  // effective limit, saturated into 1..capacity
  assign max_w = CntBits'(max_q);
  always_comb begin
    if (max_q == '0) begin
      lim_w = CntBits'(1);
    end else if (max_w > CntBits'(Capacity)) begin
      lim_w = CntBits'(Capacity);
    end else begin
      lim_w = max_w;
    end
  end
  assign lim = HeldBits'(lim_w);

  // the cell chain
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left[g] = ent[0];
    end else begin : g_rest
      assign left[g] = ent[g-1];
    end
    if (g == Capacity - 1) begin : g_wrap
      assign nxt[g] = ent[0];
    end else begin : g_mid
      assign nxt[g] = is_tail[g] ? ent[0] : ent[g+1];
    end

    topk_cell u_cell (
      .clk_i    (clk_i),
      .op_i     (op[g]),
      .new_i    (new_ent),
      .left_i   (left[g]),
      .next_i   (nxt[g]),
      .entry_o  (ent[g]),
      .older_o  (older[g]),
      .nnewer_o (nnewer[g])
    );
  end

  // per-cell flags from the compares and the fill level
  always_comb begin
    append = 1'b0;
    pos_p  = '0;
    for (int i = 0; i < Capacity; i++) begin
      below[i]   = HeldBits'(i) < held_q;
      is_tail[i] = HeldBits'(i + 1) == held_q;
      is_end[i]  = HeldBits'(i) == held_q;
    end
    below_prev[0] = 1'b1;
    older_prev[0] = 1'b1;
    for (int i = 1; i < Capacity; i++) begin
      below_prev[i] = below[i-1];
      older_prev[i] = older[i-1];
    end
    for (int i = 0; i < Capacity; i++) begin
      append   = append | (is_tail[i] & nnewer[i]);
      // first held entry not newer than the incoming stamp
      hit[i]   = below[i] & ~older[i] & older_prev[i];
      // everything past the insertion point moves down one slot
      shift[i] = ~below_prev[i] | ~older_prev[i];
      if (hit[i]) begin
        pos_p = pos_p | IdxBits'(i);
      end
    end
    if (held_q == '0) begin
      hit[0] = 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      op[i] = OP_HOLD;
      if (dumping) begin
        if (below[i]) begin
          op[i] = OP_ROTATE;
        end
      end else if (insert_go) begin
        if (append) begin
          if (is_end[i] && (held_q < lim)) begin
            op[i] = OP_LOAD;
          end
        end else if (hit[i]) begin
          op[i] = OP_LOAD;
        end else if (shift[i]) begin
          op[i] = OP_SHIFT;
        end
      end
    end
  end

  assign n1_w      = CntBits'(held_q) + CntBits'(1);
  assign ev        = n1_w > lim_w;
  assign nc        = ev ? lim : HeldBits'(n1_w);
  assign dump_last = (CntBits'(idx_q) + CntBits'(1)) == CntBits'(held_q);

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    idx_d     = idx_q;
    res_vld_d = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    if (dumping) begin
      res_vld_d         = 1'b1;
      res_d.position    = PosBits'(idx_q);
      res_d.entry_valid = 1'b1;
      res_d.entry_stamp = ent[0].stamp;
      res_d.entry_tag   = ent[0].tag;
      res_d.last        = dump_last;
      idx_d             = idx_q + IdxBits'(1);
      if (dump_last) begin
        state_d = ST_IDLE;
      end
    end else if (dump_go) begin
      if (held_q == '0) begin
        res_vld_d = 1'b1;
      end else begin
        state_d = ST_DUMP;
        idx_d   = '0;
      end
    end else if (insert_go) begin
      res_vld_d = 1'b1;
      if (append) begin
        if (held_q < lim) begin
          res_d.accepted = 1'b1;
          res_d.position = PosBits'(held_q);
          held_d         = held_q + HeldBits'(1);
        end
      end else begin
        held_d        = nc;
        res_d.evicted = ev;
        if (HeldBits'(pos_p) < nc) begin
          res_d.accepted = 1'b1;
          res_d.position = PosBits'(pos_p);
        end else begin
          res_d.evicted = 1'b1;
        end
      end
    end
    res_d.count    = CntBits'(held_d);
    res_d.full_res = held_d >= lim;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      held_q    <= '0;
      idx_q     <= '0;
      res_vld_q <= 1'b0;
      max_q     <= MaxEntriesRst;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      idx_q     <= idx_d;
      res_vld_q <= res_vld_d;
      if (cfg_wr) begin
        max_q <= pwdata[CfgBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegMaxEntries);
  assign prdata = (paddr[2] == RegMaxEntries) ? {{(32 - CfgBits){1'b0}}, max_q} : '0;

`ifndef SYNTH
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldBits'(Capacity))
    else $error("held count above capacity");

  a_dump_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (item_i.kind == KindDump)))
    else $error("busy rose without a dump item");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.entry_valid && result_o.last) |-> !busy)
    else $error("still busy after last dump beat");

  a_dump_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.entry_valid) |-> (!result_o.accepted && !result_o.evicted))
    else $error("dump beat carries insert status");
`endif

endmodule

### hdl/topk_cell.sv
// one slot of the sorted chain: holds an entry and compares it to the incoming stamp
module topk_cell import topk_pkg::*; (
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  entry_t   new_i,
  input  entry_t   left_i,
  input  entry_t   next_i,
  output entry_t   entry_o,
  output logic     older_o,
  output logic     nnewer_o
);

  entry_t entry_q, entry_d;

  // older: incoming stamp is strictly older than the held one
  assign older_o  = new_i.stamp <  entry_q.stamp;
  assign nnewer_o = new_i.stamp <= entry_q.stamp;
  assign entry_o  = entry_q;

  always_comb begin
    case (op_i)
      OP_HOLD:   entry_d = entry_q;
      OP_LOAD:   entry_d = new_i;
      OP_SHIFT:  entry_d = left_i;
      OP_ROTATE: entry_d = next_i;
      default:   entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
